// ===== hdl/wao_pkg.sv =====
// Shared constants, types and helpers for the windowed average block.
package wao_pkg;

    localparam int MAX_WINDOW  = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int LEN_BITS    = 6;
    localparam int LIMIT_BITS  = 16;
    localparam int OCL_BITS    = 8;
    localparam int SCNT_BITS   = 8;
    localparam int SLOT_BITS   = $clog2(MAX_WINDOW);
    localparam int COUNT_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS;
    localparam int STEP_BITS   = $clog2(SUM_BITS);
    localparam int OUT_BITS    = SAMPLE_BITS + SCNT_BITS;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [LEN_BITS-1:0]  RESET_WINDOW_LENGTH = LEN_BITS'(20);
    localparam logic [SCNT_BITS-1:0] COUNT_MAX           = {SCNT_BITS{1'b1}};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WINDOW_LENGTH,
        CFG_CHECK_ENABLE,
        CFG_DEVIATION_LIMIT,
        CFG_OVER_COUNT_LIMIT
    } cfg_idx_t;

    typedef enum logic {
        MODE_ADD,
        MODE_CLEAR
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_CHECK,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [SUM_BITS-1:0]   dividend;
        logic [COUNT_BITS-1:0] divisor;
    } div_req_t;

    // Zero acts as one, anything above the store depth as the depth.
    function automatic logic [COUNT_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] wl);
        logic [COUNT_BITS-1:0] len;
        if (wl == '0)
        begin
            len = COUNT_BITS'(1);
        end
        else if (int'(wl) > MAX_WINDOW)
        begin
            len = COUNT_BITS'(MAX_WINDOW);
        end
        else
        begin
            len = COUNT_BITS'(wl);
        end
        return len;
    endfunction

endpackage

// ===== hdl/wao_ram.sv =====
// Window sample store: one write port, one registered read port.
module wao_ram
    import wao_pkg::*;
(
    input  logic                   clk,
    input  logic                   we,
    input  logic [SLOT_BITS-1:0]   waddr,
    input  logic [SAMPLE_BITS-1:0] wdata,
    input  logic                   re,
    input  logic [SLOT_BITS-1:0]   raddr,
    output logic [SAMPLE_BITS-1:0] rdata
);

    logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/wao_div.sv =====
// Restoring divider for running sum over valid count, one quotient bit per cycle.
module wao_div
    import wao_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  div_req_t               req,
    output logic                   done,
    output logic [SAMPLE_BITS-1:0] quotient
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic [SUM_BITS-1:0]   quo_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [COUNT_BITS-1:0] dvs_reg;
    logic [COUNT_BITS:0]   rem_sh;
    logic                  fits;

    assign rem_sh = {rem_reg, quo_reg[SUM_BITS-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_BITS'(1);
                if (step_reg == STEP_BITS'(SUM_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_BITS-2:0], fits};
            rem_reg <= fits ? COUNT_BITS'(rem_sh - {1'b0, dvs_reg}) : COUNT_BITS'(rem_sh);
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[SAMPLE_BITS-1:0];

endmodule

// ===== hdl/windowed_average_outlier_reset.sv =====
// An add item passes the update, divide, check and output states in order; a clear item goes
// straight to output. A new item is taken only in idle, after the last result is registered; the
// divide of the running sum by the valid count takes 21 steps. The result sits in an output register.
// Reset: valid marks, write slot, sum, counts and configuration go to their
// reset values at once; the sample store itself is not cleared.
module windowed_average_outlier_reset
    import wao_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [SAMPLE_BITS-1:0]  s_axis_tdata,   // [15:0] sample
    input  logic                    s_axis_tuser,   // [0] mode
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_BITS-1:0]     m_axis_tdata,   // [15:0] average, [23:16] sample_count
    output logic [1:0]              m_axis_tuser,   // [0] restarted, [1] over_count
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [LIMIT_BITS-1:0]   cfg_data
);

    state_t                  state_reg, state_next;
    logic [SAMPLE_BITS-1:0]  sample_reg, sample_next;
    logic [SLOT_BITS-1:0]    slot_reg, slot_next;
    logic [SLOT_BITS-1:0]    wslot_reg, wslot_next;
    logic [SUM_BITS-1:0]     sum_reg, sum_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [SCNT_BITS-1:0]    scnt_reg, scnt_next;
    logic [MAX_WINDOW-1:0]   valid_reg, valid_next;
    logic [SAMPLE_BITS-1:0]  avg_reg, avg_next;
    logic                    restart_reg, restart_next;
    logic                    ovalid_reg, ovalid_next;
    logic [OUT_BITS-1:0]     odata_reg, odata_next;
    logic [1:0]              ouser_reg, ouser_next;

    logic [LEN_BITS-1:0]     wl_reg;
    logic                    chk_en_reg;
    logic [LIMIT_BITS-1:0]   dev_lim_reg;
    logic [OCL_BITS-1:0]     oc_lim_reg;

    logic [COUNT_BITS-1:0]   len;
    logic [SLOT_BITS-1:0]    slot_sel;
    logic [COUNT_BITS-1:0]   slot_inc;
    logic [SAMPLE_BITS-1:0]  old_val;
    logic [SAMPLE_BITS-1:0]  diff;
    logic                    s_xfer;
    logic                    out_free;
    logic                    over_flag;

    logic                    ram_we;
    logic [SLOT_BITS-1:0]    ram_waddr;
    logic [SAMPLE_BITS-1:0]  ram_rdata;
    div_req_t                div_req;
    logic                    div_done;
    logic [SAMPLE_BITS-1:0]  div_quo;

    wao_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sample_reg),
        .re    (s_xfer),
        .raddr (slot_sel),
        .rdata (ram_rdata)
    );

    wao_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg      <= RESET_WINDOW_LENGTH;
            chk_en_reg  <= 1'b0;
            dev_lim_reg <= '0;
            oc_lim_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_WINDOW_LENGTH:    wl_reg      <= cfg_data[LEN_BITS-1:0];
                CFG_CHECK_ENABLE:     chk_en_reg  <= cfg_data[0];
                CFG_DEVIATION_LIMIT:  dev_lim_reg <= cfg_data;
                CFG_OVER_COUNT_LIMIT: oc_lim_reg  <= cfg_data[OCL_BITS-1:0];
                default:              ;
            endcase
        end
    end

    assign len       = eff_len(wl_reg);
    assign slot_sel  = (COUNT_BITS'(wslot_reg) >= len) ? '0 : wslot_reg;
    assign slot_inc  = COUNT_BITS'(slot_reg) + COUNT_BITS'(1);
    assign old_val   = valid_reg[slot_reg] ? ram_rdata : '0;
    assign diff      = (avg_reg > sample_reg) ? (avg_reg - sample_reg) : (sample_reg - avg_reg);
    assign s_xfer    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !ovalid_reg || m_axis_tready;
    assign over_flag = (oc_lim_reg != '0) && (scnt_reg > oc_lim_reg);

    always_comb
    begin
        state_next   = state_reg;
        sample_next  = sample_reg;
        slot_next    = slot_reg;
        wslot_next   = wslot_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        scnt_next    = scnt_reg;
        valid_next   = valid_reg;
        avg_next     = avg_reg;
        restart_next = restart_reg;
        ovalid_next  = ovalid_reg;
        odata_next   = odata_reg;
        ouser_next   = ouser_reg;
        ram_we       = 1'b0;
        ram_waddr    = slot_reg;
        div_req      = '{start: 1'b0, dividend: '0, divisor: '0};
        s_axis_tready = (state_reg == ST_IDLE);

        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    sample_next  = s_axis_tdata;
                    slot_next    = slot_sel;
                    restart_next = 1'b0;
                    if (mode_t'(s_axis_tuser) == MODE_CLEAR)
                    begin
                        valid_next = '0;
                        wslot_next = '0;
                        sum_next   = '0;
                        count_next = '0;
                        scnt_next  = '0;
                        avg_next   = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE:
            begin
                ram_we               = 1'b1;
                valid_next[slot_reg] = 1'b1;
                sum_next   = sum_reg - SUM_BITS'(old_val) + SUM_BITS'(sample_reg);
                count_next = valid_reg[slot_reg] ? count_reg : count_reg + COUNT_BITS'(1);
                wslot_next = (slot_inc >= len) ? '0 : SLOT_BITS'(slot_inc);
                if (scnt_reg != COUNT_MAX)
                begin
                    scnt_next = scnt_reg + SCNT_BITS'(1);
                end
                div_req    = '{start: 1'b1, dividend: sum_next, divisor: count_next};
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    avg_next   = div_quo;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (chk_en_reg && (diff > dev_lim_reg))
                begin
                    // Outlier: restart the window holding this sample alone.
                    ram_we        = 1'b1;
                    ram_waddr     = '0;
                    valid_next    = '0;
                    valid_next[0] = 1'b1;
                    sum_next      = SUM_BITS'(sample_reg);
                    count_next    = COUNT_BITS'(1);
                    wslot_next    = (len == COUNT_BITS'(1)) ? '0 : SLOT_BITS'(1);
                    scnt_next     = SCNT_BITS'(1);
                    avg_next      = sample_reg;
                    restart_next  = 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {scnt_reg, avg_reg};
                    ouser_next  = {over_flag, restart_reg};
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wslot_reg  <= '0;
            sum_reg    <= '0;
            count_reg  <= '0;
            scnt_reg   <= '0;
            valid_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wslot_reg  <= wslot_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            scnt_reg   <= scnt_next;
            valid_reg  <= valid_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        slot_reg    <= slot_next;
        avg_reg     <= avg_next;
        restart_reg <= restart_next;
        odata_reg   <= odata_next;
        ouser_reg   <= ouser_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ouser_reg;

endmodule

// ===== hdl/wao_chk.sv =====
// Port-level checks for the windowed average block, bound to the top level.
module wao_chk
    import wao_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OUT_BITS-1:0] m_axis_tdata,
    input logic [1:0]          m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transfer taken while item in flight");

    a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[OUT_BITS-1:SAMPLE_BITS] == SCNT_BITS'(1))
        else $error("restart result without count of one");

    a_over_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tdata[OUT_BITS-1:SAMPLE_BITS] != '0)
        else $error("over-count flag with zero count");

endmodule

bind windowed_average_outlier_reset wao_chk u_wao_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
